// ----- src/trl_pkg.sv -----
// Shared types and constants for the transmit rate limiter.
package trl_pkg;

    // Fixed field widths.
    localparam int TIME_BITS = 48;
    localparam int CFG_W     = 32;
    localparam int LIMIT_W   = 6;
    localparam int STATUS_W  = 3;
    localparam int INDEX_W   = 3;

    // Configuration register indexes.
    localparam logic [INDEX_W-1:0] REG_FIRE_GAP    = 3'd0;
    localparam logic [INDEX_W-1:0] REG_CONTROL_GAP = 3'd1;
    localparam logic [INDEX_W-1:0] REG_WINDOW      = 3'd2;
    localparam logic [INDEX_W-1:0] REG_LOCKOUT     = 3'd3;
    localparam logic [INDEX_W-1:0] REG_FIRE_LIMIT  = 3'd4;

    // Configuration reset values.
    localparam logic [CFG_W-1:0]   FIRE_GAP_RESET    = 32'd1000;
    localparam logic [CFG_W-1:0]   CONTROL_GAP_RESET = 32'd6000;
    localparam logic [CFG_W-1:0]   WINDOW_RESET      = 32'd60000;
    localparam logic [CFG_W-1:0]   LOCKOUT_RESET     = 32'd2000;
    localparam logic [LIMIT_W-1:0] FIRE_LIMIT_RESET  = 6'd30;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_SENT     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_LOCKOUT  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_SOON = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_WFULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FRAME    = 3'd4;

    // Input item kinds.
    localparam logic FUNC_SEND  = 1'b0;
    localparam logic FUNC_FRAME = 1'b1;

    // Input beat.
    typedef struct packed {
        logic                 func;
        logic [TIME_BITS-1:0] now;
        logic                 is_fire;
    } trl_in_t;

    // Output beat.
    typedef struct packed {
        logic                granted;
        logic [STATUS_W-1:0] status;
        logic [LIMIT_W-1:0]  fires_in_window;
    } trl_out_t;

    // Request to the shared add/subtract/compare unit.
    typedef struct packed {
        logic                 sub;
        logic [TIME_BITS-1:0] a;
        logic [TIME_BITS-1:0] b;
        logic [CFG_W-1:0]     lim;
    } trl_alu_req_t;

    // Result of the shared unit.
    typedef struct packed {
        logic [TIME_BITS-1:0] sum;
        logic                 carry;
        logic                 lt;
    } trl_alu_res_t;

    // Fire timestamp queue controls.
    typedef struct packed {
        logic push;
        logic pop;
    } trl_fifo_ctl_t;

endpackage

// ----- src/trl_alu.sv -----
// Shared add/subtract unit with a compare of the result against a limit.
module trl_alu
    import trl_pkg::*;
(
    input  trl_alu_req_t req,
    output trl_alu_res_t res
);

    logic [TIME_BITS-1:0] b_eff;
    logic [TIME_BITS:0]   total;

    // Subtraction is a + ~b + 1; the carry out is the "no borrow" flag.
    assign b_eff = req.sub ? ~req.b : req.b;
    assign total = {1'b0, req.a} + {1'b0, b_eff} + (TIME_BITS + 1)'(req.sub);

    // Compare the low bits of the result against the zero-extended limit.
    assign res.sum   = total[TIME_BITS-1:0];
    assign res.carry = total[TIME_BITS];
    assign res.lt    = total[TIME_BITS-1:0] < TIME_BITS'(req.lim);

endmodule

// ----- src/trl_fifo.sv -----
// Circular queue of granted fire timestamps with a registered head read.
module trl_fifo
    import trl_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int CNT_W = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  trl_fifo_ctl_t        ctl,
    input  logic [TIME_BITS-1:0] push_data,
    output logic [TIME_BITS-1:0] head_data,
    output logic [CNT_W-1:0]     count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [TIME_BITS-1:0] mem [DEPTH];
    logic [PTR_W-1:0]     head_reg;
    logic [PTR_W-1:0]     head_next;
    logic [PTR_W-1:0]     tail_reg;
    logic [PTR_W-1:0]     tail_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [TIME_BITS-1:0] rd_data_reg;

    // Pointer and occupancy updates with wrap at the queue depth.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (ctl.push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (ctl.push && !ctl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop && !ctl.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage: write at the tail, registered read at the head.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= push_data;
        end
        rd_data_reg <= mem[head_reg];
    end

    assign head_data = rd_data_reg;
    assign count     = count_reg;

    // A pop needs a held entry.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> count_reg != '0)
        else $error("fire queue popped while empty");

    // A push needs a free entry.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> count_reg < CNT_W'(DEPTH))
        else $error("fire queue pushed while full");

endmodule

// ----- src/transmit_rate_limiter_core.sv -----
// The sequencer steps a frame through S_FRAME and a send through S_LOCK and, unless locked
// out, S_GAP; a fire send that passes the gap check with timestamps held then takes S_EXP_RD
// and S_EXP_CHK per timestamp examined. S_DONE loads the result beat into the output register.
// One item at a time: a new item is taken only in S_IDLE; S_DONE waits on an untaken result.
// Reset clears configuration to defaults, lockout and last-send times, and the fire count;
// queue storage is not cleared and is only read below the count.
module transmit_rate_limiter_core
    import trl_pkg::*;
#(
    parameter int MAX_FIRES = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  trl_in_t            in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output trl_out_t           out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(MAX_FIRES + 1);
    localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_FRAME   = 7'b0000010,
        S_LOCK    = 7'b0000100,
        S_GAP     = 7'b0001000,
        S_EXP_RD  = 7'b0010000,
        S_EXP_CHK = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    trl_in_t              in_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [TIME_BITS-1:0] lockout_until_reg;
    logic [TIME_BITS-1:0] lockout_until_next;
    logic [TIME_BITS-1:0] last_send_reg;
    logic [TIME_BITS-1:0] last_send_next;
    logic [CFG_W-1:0]     fire_gap_reg;
    logic [CFG_W-1:0]     control_gap_reg;
    logic [CFG_W-1:0]     window_reg;
    logic [CFG_W-1:0]     lockout_reg;
    logic [LIMIT_W-1:0]   fire_limit_reg;
    logic                 out_valid_reg;
    trl_out_t             out_data_reg;

    trl_alu_req_t         alu_req;
    trl_alu_res_t         alu_res;
    trl_fifo_ctl_t        fifo_ctl;
    logic [TIME_BITS-1:0] head_data;
    logic [CNT_W-1:0]     fire_count;

    logic                 in_fire;
    logic                 load_out;
    logic [LIM_W-1:0]     limit;
    logic                 window_full;
    logic [STATUS_W-1:0]  final_status;
    logic                 grant;
    logic [LIM_W-1:0]     fires_after;
    trl_out_t             out_next;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fire_gap_reg    <= FIRE_GAP_RESET;
            control_gap_reg <= CONTROL_GAP_RESET;
            window_reg      <= WINDOW_RESET;
            lockout_reg     <= LOCKOUT_RESET;
            fire_limit_reg  <= FIRE_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FIRE_GAP:    fire_gap_reg    <= cfg_data;
                REG_CONTROL_GAP: control_gap_reg <= cfg_data;
                REG_WINDOW:      window_reg      <= cfg_data;
                REG_LOCKOUT:     lockout_reg     <= cfg_data;
                REG_FIRE_LIMIT:  fire_limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Operand selection for the shared unit, by sequencer step.
    always_comb
    begin
        alu_req.sub = 1'b1;
        alu_req.a   = in_reg.now;
        alu_req.b   = lockout_until_reg;
        alu_req.lim = window_reg;
        case (state_reg)
            S_FRAME:
            begin
                alu_req.sub = 1'b0;
                alu_req.b   = TIME_BITS'(lockout_reg);
            end
            S_GAP:
            begin
                alu_req.b   = last_send_reg;
                alu_req.lim = in_reg.is_fire ? fire_gap_reg : control_gap_reg;
            end
            S_EXP_CHK:
            begin
                alu_req.b = head_data;
            end
            default: ;
        endcase
    end

    trl_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // Window-full decision and the result beat.
    always_comb
    begin
        limit        = (LIM_W'(fire_limit_reg) > LIM_W'(MAX_FIRES)) ?
                       LIM_W'(MAX_FIRES) : LIM_W'(fire_limit_reg);
        window_full  = LIM_W'(fire_count) >= limit;
        final_status = status_reg;
        if (status_reg == STATUS_SENT && in_reg.is_fire && window_full)
        begin
            final_status = STATUS_WFULL;
        end
        grant        = (final_status == STATUS_SENT);
        fires_after  = LIM_W'(fire_count) + LIM_W'(grant && in_reg.is_fire);
        out_next.granted         = grant;
        out_next.status          = final_status;
        out_next.fires_in_window = fires_after[LIMIT_W-1:0];
    end

    // Sequencer: one check per cycle through the shared unit, bar queue-read waits and stalls.
    always_comb
    begin
        state_next         = state_reg;
        status_next        = status_reg;
        lockout_until_next = lockout_until_reg;
        last_send_next     = last_send_reg;
        fifo_ctl.push      = 1'b0;
        fifo_ctl.pop       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    status_next = STATUS_SENT;
                    state_next  = (in_data.func == FUNC_FRAME) ? S_FRAME : S_LOCK;
                end
            end
            S_FRAME:
            begin
                status_next = STATUS_FRAME;
                if (in_reg.is_fire)
                begin
                    lockout_until_next = alu_res.carry ? '1 : alu_res.sum;
                end
                state_next = S_DONE;
            end
            S_LOCK:
            begin
                // No carry out of now - lockout_until means now is still inside it.
                if (!alu_res.carry)
                begin
                    status_next = STATUS_LOCKOUT;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                if (last_send_reg != '0 && alu_res.lt)
                begin
                    status_next = STATUS_TOO_SOON;
                    state_next  = S_DONE;
                end
                else if (in_reg.is_fire && fire_count != '0)
                begin
                    state_next = S_EXP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_EXP_RD:
            begin
                // Wait for the head entry to come out of the queue storage.
                state_next = S_EXP_CHK;
            end
            S_EXP_CHK:
            begin
                if (!alu_res.lt)
                begin
                    fifo_ctl.pop = 1'b1;
                    state_next   = (fire_count == CNT_W'(1)) ? S_DONE : S_EXP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    if (grant)
                    begin
                        last_send_next = in_reg.now;
                        fifo_ctl.push  = in_reg.is_fire;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            status_reg        <= STATUS_SENT;
            lockout_until_reg <= '0;
            last_send_reg     <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            status_reg        <= status_next;
            lockout_until_reg <= lockout_until_next;
            last_send_reg     <= last_send_next;
        end
    end

    // Accepted item is held for the whole sequence.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_reg <= in_data;
        end
    end

    trl_fifo #(
        .DEPTH (MAX_FIRES),
        .CNT_W (CNT_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (fifo_ctl),
        .push_data (in_reg.now),
        .head_data (head_data),
        .count     (fire_count)
    );

    // Output register parts the result from the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Only one item is in the sequencer at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("second item accepted while one is in progress");

    // A granted result records the item's time as the last send.
    a_last_send: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && grant) |=> last_send_reg == $past(in_reg.now))
        else $error("granted send did not record its time");

    // A frame never yields a grant.
    a_frame_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && in_reg.func == FUNC_FRAME) |-> (!grant && final_status == STATUS_FRAME))
        else $error("frame produced a grant or wrong status");

    // Held fire count stays within the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fire_count <= CNT_W'(MAX_FIRES))
        else $error("fire count beyond queue depth");

endmodule

// ----- test/transmit_rate_limiter_core_tb.sv -----
// Self-checking testbench for the transmit rate limiter core: directed beats, then random phases.
`timescale 1ns / 100ps

module transmit_rate_limiter_core_tb
    import trl_pkg::*;
();

    localparam int FIRE_DEPTH       = 32;
    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 7;
    localparam int PHASE_COUNT      = 12;
    localparam int RANDOM_PER_PHASE = 119;
    localparam int SETTLE_CYCLES    = 8;
    localparam int MAX_REPORTS      = 10;
    localparam int WATCHDOG_LIMIT   = 2000;

    // One register setting plus the typical time step used while it is active.
    typedef struct packed {
        logic [CFG_W-1:0]   fire_gap;
        logic [CFG_W-1:0]   control_gap;
        logic [CFG_W-1:0]   window;
        logic [CFG_W-1:0]   lockout;
        logic [LIMIT_W-1:0] fire_limit;
        logic [CFG_W-1:0]   pace;
    } phase_cfg_t;

    // A directed beat; pinned rows carry an outcome written out by hand.
    typedef struct packed {
        trl_in_t  beat;
        logic     pinned;
        trl_out_t outcome;
    } directed_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_THIRD, RX_SPARSE} rx_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    trl_in_t            in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    trl_out_t           out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    // Shadow configuration and limiter state.
    logic [CFG_W-1:0]     fire_gap_q;
    logic [CFG_W-1:0]     control_gap_q;
    logic [CFG_W-1:0]     window_q;
    logic [CFG_W-1:0]     lockout_q;
    logic [LIMIT_W-1:0]   fire_limit_q;
    logic [TIME_BITS-1:0] lockout_end;
    logic [TIME_BITS-1:0] last_grant;
    logic [TIME_BITS-1:0] fire_stamps [FIRE_DEPTH];
    logic [LIMIT_W-1:0]   fire_held;

    trl_out_t             outcome_q [$];
    directed_row_t        typed_outcome_q [$];
    directed_row_t        directed_rows [$];
    int unsigned          fail_count = 0;
    logic [TIME_BITS-1:0] clock_ticks = '0;
    int unsigned          burst_left = 0;

    rx_mode_t             rx_mode = RX_OPEN;
    int unsigned          rx_left = 0;
    int unsigned          rx_phase = 0;

    transmit_rate_limiter_core #(
        .MAX_FIRES (FIRE_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Works out the result of one accepted beat and advances the shadow state.
    function automatic trl_out_t predict_outcome(input trl_in_t beat);
        trl_out_t             res;
        logic [TIME_BITS:0]   lock_sum;
        logic [TIME_BITS-1:0] since_last;
        logic [TIME_BITS-1:0] gap_needed;
        logic [TIME_BITS-1:0] age;
        logic [TIME_BITS-1:0] span;
        int unsigned          limit_eff;
        int unsigned          expired;
        res.granted = 1'b0;
        res.status = STATUS_SENT;
        limit_eff = (fire_limit_q < FIRE_DEPTH) ? int'(fire_limit_q) : FIRE_DEPTH;
        span = TIME_BITS'(window_q);
        if (beat.func == FUNC_FRAME) begin
            res.status = STATUS_FRAME;
            // A fire frame locks sends out; the end saturates at the largest time.
            if (beat.is_fire) begin
                lock_sum = {1'b0, beat.now} + (TIME_BITS + 1)'(lockout_q);
                lockout_end = lock_sum[TIME_BITS] ? '1 : lock_sum[TIME_BITS-1:0];
            end
        end else if (beat.now < lockout_end) begin
            res.status = STATUS_LOCKOUT;
        end else begin
            since_last = beat.now - last_grant;
            gap_needed = beat.is_fire ? TIME_BITS'(fire_gap_q) : TIME_BITS'(control_gap_q);
            if (last_grant != '0 && since_last < gap_needed) begin
                res.status = STATUS_TOO_SOON;
            end else begin
                // Fire sends first age out old stamps, then check the window count.
                if (beat.is_fire) begin
                    expired = 0;
                    age = beat.now - fire_stamps[0];
                    while (expired < fire_held && age >= span) begin
                        expired++;
                        if (expired < FIRE_DEPTH)
                            age = beat.now - fire_stamps[expired];
                    end
                    for (int i = 0; i + expired < fire_held; i++)
                        fire_stamps[i] = fire_stamps[i + expired];
                    fire_held = fire_held - LIMIT_W'(expired);
                    if (fire_held >= limit_eff)
                        res.status = STATUS_WFULL;
                end
                if (res.status == STATUS_SENT) begin
                    res.granted = 1'b1;
                    last_grant = beat.now;
                    if (beat.is_fire && fire_held < FIRE_DEPTH) begin
                        fire_stamps[fire_held] = beat.now;
                        fire_held = fire_held + 1'b1;
                    end
                end
            end
        end
        res.fires_in_window = fire_held;
        return res;
    endfunction

    // Next random beat: mostly forward steps near the phase pace, some jumps and time resets.
    function automatic trl_in_t random_beat(input logic [CFG_W-1:0] pace);
        trl_in_t              beat;
        logic [63:0]          wide;
        logic [TIME_BITS-1:0] stride;
        int unsigned          pick;
        wide = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        stride = TIME_BITS'($urandom_range(0, pace));
        if (pick < 8)
            stride = '0;
        else if (pick >= 68 && pick < 88)
            stride = stride * TIME_BITS'($urandom_range(2, 4));
        else if (pick >= 88 && pick < 95)
            stride = wide[TIME_BITS-1:0] >> $urandom_range(8, 24);
        if (pick < 95)
            clock_ticks = clock_ticks + stride;
        else
            clock_ticks = wide[TIME_BITS-1:0];
        beat.func = ($urandom_range(0, 99) < 15) ? FUNC_FRAME : FUNC_SEND;
        beat.now = clock_ticks;
        beat.is_fire = 1'($urandom_range(0, 1));
        return beat;
    endfunction

    function automatic phase_cfg_t make_phase(input logic [CFG_W-1:0] fire_gap,
                                              input logic [CFG_W-1:0] control_gap,
                                              input logic [CFG_W-1:0] window,
                                              input logic [CFG_W-1:0] lockout,
                                              input logic [LIMIT_W-1:0] fire_limit,
                                              input logic [CFG_W-1:0] pace);
        phase_cfg_t cfg;
        cfg.fire_gap = fire_gap;
        cfg.control_gap = control_gap;
        cfg.window = window;
        cfg.lockout = lockout;
        cfg.fire_limit = fire_limit;
        cfg.pace = pace;
        return cfg;
    endfunction

    function automatic void add_row(input logic func, input logic [TIME_BITS-1:0] now,
                                    input logic is_fire, input logic pinned,
                                    input logic granted, input logic [STATUS_W-1:0] status,
                                    input logic [LIMIT_W-1:0] held);
        directed_row_t row;
        row.beat.func = func;
        row.beat.now = now;
        row.beat.is_fire = is_fire;
        row.pinned = pinned;
        row.outcome.granted = granted;
        row.outcome.status = status;
        row.outcome.fires_in_window = held;
        directed_rows.push_back(row);
    endfunction

    // Raises valid with a beat and returns at the edge where it is taken.
    task automatic drive_beat(input trl_in_t beat);
        in_valid <= 1'b1;
        in_data <= beat;
        do @(posedge clk); while (!in_ready);
    endtask

    // Burst accounting: at the end of a burst, maybe drop valid for a random gap.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Leaves valid high between writes so it never drops and rises in one step.
    task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Writes every register, the limit with junk in its unused bits, plus one stray index.
    task automatic program_regs(input phase_cfg_t cfg);
        logic [CFG_W-1:0]   junk;
        logic [INDEX_W-1:0] stray;
        junk = $urandom;
        stray = REG_FIRE_LIMIT + INDEX_W'($urandom_range(1, 3));
        write_reg(REG_FIRE_GAP, cfg.fire_gap);
        write_reg(REG_CONTROL_GAP, cfg.control_gap);
        write_reg(REG_WINDOW, cfg.window);
        write_reg(REG_LOCKOUT, cfg.lockout);
        write_reg(REG_FIRE_LIMIT, {junk[CFG_W-1:LIMIT_W], cfg.fire_limit});
        write_reg(stray, junk);
        cfg_valid <= 1'b0;
    endtask

    // Drains the block: one edge so the last accept is recorded, then wait out the results.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outcome_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver backpressure: a mode picked at random holds for a random stretch.
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 150);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            RX_OPEN:  out_ready <= 1'b1;
            RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
            RX_THIRD: out_ready <= (rx_phase % 3) == 0;
            default:  out_ready <= (rx_phase % 6) == 0;
        endcase
    end

    // Scoreboard: predicts on input beats, checks output beats in order.
    always @(posedge clk) begin : scoreboard
        trl_out_t      predicted;
        trl_out_t      want;
        directed_row_t row;
        if (!rst_n) begin
            fire_gap_q = FIRE_GAP_RESET;
            control_gap_q = CONTROL_GAP_RESET;
            window_q = WINDOW_RESET;
            lockout_q = LOCKOUT_RESET;
            fire_limit_q = FIRE_LIMIT_RESET;
            lockout_end = '0;
            last_grant = '0;
            fire_held = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FIRE_GAP:    fire_gap_q = cfg_data;
                    REG_CONTROL_GAP: control_gap_q = cfg_data;
                    REG_WINDOW:      window_q = cfg_data;
                    REG_LOCKOUT:     lockout_q = cfg_data;
                    REG_FIRE_LIMIT:  fire_limit_q = cfg_data[LIMIT_W-1:0];
                    default:         ;
                endcase
            end
            if (in_valid && in_ready) begin
                predicted = predict_outcome(in_data);
                if (typed_outcome_q.size() != 0) begin
                    row = typed_outcome_q.pop_front();
                    if (row.pinned)
                        predicted = row.outcome;
                end
                outcome_q.push_back(predicted);
            end
            if (out_valid && out_ready) begin
                if (outcome_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result: granted %0b status %0d held %0d",
                                 $time, out_data.granted, out_data.status,
                                 out_data.fires_in_window);
                end else begin
                    want = outcome_q.pop_front();
                    if (out_data.granted !== want.granted || out_data.status !== want.status ||
                        out_data.fires_in_window !== want.fires_in_window) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: exp/act granted %0b/%0b status %0d/%0d held %0d/%0d",
                                     $time, want.granted, out_data.granted, want.status,
                                     out_data.status, want.fires_in_window,
                                     out_data.fires_in_window);
                    end
                end
            end
        end
    end

    // Ends the run if no channel moves a beat for too long.
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        phase_cfg_t plan [PHASE_COUNT];
        // Extremes first: reset values, everything at maximum, everything zero,
        // a limit of one, and a full queue with a wide window; then random settings.
        plan[0] = make_phase(FIRE_GAP_RESET, CONTROL_GAP_RESET, WINDOW_RESET, LOCKOUT_RESET,
                             FIRE_LIMIT_RESET, 800);
        plan[1] = make_phase('1, '1, '1, '1, '1, '1);
        plan[2] = make_phase('0, '0, '0, '0, '0, 50);
        plan[3] = make_phase(10, 20, 5000, 100, 6'd1, 200);
        plan[4] = make_phase('0, '0, '1, '0, 6'd32, 20);
        for (int p = 5; p < PHASE_COUNT; p++)
            plan[p] = make_phase($urandom_range(0, 50), $urandom_range(0, 150),
                                 $urandom_range(0, 3000), $urandom_range(0, 400),
                                 LIMIT_W'($urandom_range(0, 40)), $urandom_range(10, 120));

        // Directed beats under reset settings.
        // A send at time zero still reads as no send yet.
        add_row(FUNC_SEND,  48'd0,    1'b0, 1'b1, 1'b1, STATUS_SENT,     6'd0);
        add_row(FUNC_SEND,  48'd10,   1'b0, 1'b1, 1'b1, STATUS_SENT,     6'd0);
        add_row(FUNC_SEND,  48'd20,   1'b1, 1'b1, 1'b0, STATUS_TOO_SOON, 6'd0);
        add_row(FUNC_SEND,  48'd1010, 1'b1, 1'b1, 1'b1, STATUS_SENT,     6'd1);
        add_row(FUNC_FRAME, 48'd1100, 1'b1, 1'b1, 1'b0, STATUS_FRAME,    6'd1);
        add_row(FUNC_SEND,  48'd3099, 1'b0, 1'b1, 1'b0, STATUS_LOCKOUT,  6'd1);
        add_row(FUNC_SEND,  48'd3100, 1'b1, 1'b0, 1'b0, STATUS_SENT,     6'd0);
        // A non-fire frame leaves the state alone.
        add_row(FUNC_FRAME, 48'd3200, 1'b0, 1'b1, 1'b0, STATUS_FRAME,    6'd2);
        add_row(FUNC_SEND,  48'd9099, 1'b0, 1'b0, 1'b0, STATUS_SENT,     6'd0);
        add_row(FUNC_SEND,  48'd9100, 1'b0, 1'b0, 1'b0, STATUS_SENT,     6'd0);
        // Both stamps age out, one of them exactly at the window length.
        add_row(FUNC_SEND,  48'd63100, 1'b1, 1'b0, 1'b0, STATUS_SENT,    6'd0);
        // Lockout end saturates near the top of the time range.
        add_row(FUNC_FRAME, 48'hFFFF_FFFF_FC18, 1'b1, 1'b1, 1'b0, STATUS_FRAME, 6'd1);
        add_row(FUNC_SEND,  48'hFFFF_FFFF_FFFE, 1'b0, 1'b1, 1'b0, STATUS_LOCKOUT, 6'd1);
        add_row(FUNC_SEND,  48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, STATUS_SENT, 6'd0);
        // Time steps backwards: small differences wrap around.
        add_row(FUNC_FRAME, 48'd0,    1'b1, 1'b1, 1'b0, STATUS_FRAME,    6'd1);
        add_row(FUNC_SEND,  48'd1999, 1'b0, 1'b1, 1'b0, STATUS_LOCKOUT,  6'd1);
        add_row(FUNC_SEND,  48'd4000, 1'b0, 1'b0, 1'b0, STATUS_SENT,     6'd0);
        add_row(FUNC_SEND,  48'd5000, 1'b1, 1'b0, 1'b0, STATUS_SENT,     6'd0);
        add_row(FUNC_SEND,  48'h0000_8000_0000, 1'b1, 1'b0, 1'b0, STATUS_SENT, 6'd0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p != 0)
                program_regs(plan[p]);
            if (p == 0) begin
                foreach (directed_rows[r]) begin
                    typed_outcome_q.push_back(directed_rows[r]);
                    drive_beat(directed_rows[r].beat);
                    pace_sender();
                end
                clock_ticks = directed_rows[directed_rows.size() - 1].beat.now;
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                drive_beat(random_beat(plan[p].pace));
                if (n != RANDOM_PER_PHASE - 1)
                    pace_sender();
            end
            settle();
        end

        if (fail_count == 0 && outcome_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
